>>> design/ced_pkg.sv
// Shared types, constants and codes for the compass edge detector.
package ced_pkg;

    localparam int PIX_W     = 8;
    localparam int MAG_W     = 10;
    localparam int THR_W     = 10;
    localparam int IMG_W_W   = 10;
    localparam int IMG_H_W   = 13;
    localparam int RESP_W    = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    localparam int MAX_WIDTH_DEF    = 512;
    localparam int QUEUE_DEPTH_DEF  = 4;
    localparam int RESULT_DEPTH_DEF = 4;
    localparam int MIN_DIM          = 3;
    localparam int MAX_HEIGHT       = 4096;

    localparam logic [THR_W-1:0]   THRESHOLD_RESET = THR_W'(43);
    localparam logic [IMG_W_W-1:0] WIDTH_RESET     = IMG_W_W'(512);
    localparam logic [IMG_H_W-1:0] HEIGHT_RESET    = IMG_H_W'(512);

    localparam logic [PIX_W-1:0] EDGE_OUT    = PIX_W'(0);
    localparam logic [PIX_W-1:0] NO_EDGE_OUT = PIX_W'(255);

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = CFG_IDX_W'(2);

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel_in;
    } in_item_t;

    typedef struct packed {
        logic [PIX_W-1:0] edge_pixel;
        logic [MAG_W-1:0] magnitude;
        logic             last_in_run;
    } out_item_t;

    typedef struct packed {
        logic [IMG_W_W-1:0] image_width;
        logic [IMG_H_W-1:0] image_height;
    } frame_cfg_t;

    // window indexed [row][column], row 0 on top, column 0 on the left
    typedef struct packed {
        logic [2:0][2:0][PIX_W-1:0] win;
        logic                       emit_mid;
        logic                       emit_edge;
    } win_rec_t;

    typedef enum logic {
        PH_FIRST,
        PH_SECOND
    } back_phase_t;

endpackage

>>> design/ced_queue.sv
// Small first-word-fall-through queue with an occupancy count.
module ced_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wr_data,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rd_data,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic                       empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    assign rd_data = store_reg[rd_ptr_reg];
    assign count   = count_reg;
    assign empty   = (count_reg == '0);

endmodule

>>> design/ced_front.sv
// Front end: raster counters, line buffers and the 3x3 window, feeding window records.
module ced_front
    import ced_pkg::*;
#(
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  in_item_t                         pixel_item,
    input  frame_cfg_t                       frame_cfg,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
    output logic                             q_push,
    output win_rec_t                         q_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WBITS = $clog2(MAX_WIDTH + 1);
    localparam int CW    = (IMG_W_W > WBITS) ? IMG_W_W : WBITS;
    localparam int QC_W  = $clog2(QUEUE_DEPTH + 1);

    logic [PIX_W-1:0] above_mem [MAX_WIDTH];
    logic [PIX_W-1:0] mid_mem   [MAX_WIDTH];
    logic [PIX_W-1:0] above_rd_reg;
    logic [PIX_W-1:0] mid_rd_reg;

    logic [COL_W-1:0]   col_reg, col_next;
    logic [IMG_H_W-1:0] row_reg, row_next;

    logic               s1_valid_reg;
    logic               s1_op_reg;
    logic [PIX_W-1:0]   s1_px_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic               s1_r1_reg;
    logic               s1_r2_reg;
    logic               s1_last_reg;
    logic               s1_c0_reg;

    logic [2:0][2:0][PIX_W-1:0] win_reg, win_next;

    logic [CW-1:0]      w_cfg, w_eff, w_last;
    logic [IMG_H_W-1:0] h_eff;
    logic               in_fire, go, last_a;
    logic [PIX_W-1:0]   px_v, px_mid, px_top;
    logic [2:0][PIX_W-1:0] new_col;
    logic               e_mid, e_edge;

    // clamp frame size to the supported range
    always_comb
    begin
        w_cfg = CW'(frame_cfg.image_width);
        if (w_cfg < CW'(MIN_DIM))
            w_eff = CW'(MIN_DIM);
        else if (w_cfg > CW'(MAX_WIDTH))
            w_eff = CW'(MAX_WIDTH);
        else
            w_eff = w_cfg;
        w_last = w_eff - CW'(1);

        if (frame_cfg.image_height < IMG_H_W'(MIN_DIM))
            h_eff = IMG_H_W'(MIN_DIM);
        else if (frame_cfg.image_height > IMG_H_W'(MAX_HEIGHT))
            h_eff = IMG_H_W'(MAX_HEIGHT);
        else
            h_eff = frame_cfg.image_height;
    end

    assign full = ((QC_W + 1)'(q_count) + (QC_W + 1)'(s1_valid_reg))
                  >= (QC_W + 1)'(QUEUE_DEPTH);
    assign in_fire = push && !full;
    // flush in the top row is dropped
    assign go      = in_fire && !((pixel_item.op == OP_FLUSH) && (row_reg == '0));
    assign last_a  = (CW'(col_reg) >= w_last);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (go)
        begin
            if (last_a)
            begin
                col_next = '0;
                row_next = (row_reg >= h_eff) ? '0 : row_reg + IMG_H_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= go;
            win_reg      <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            s1_op_reg    <= pixel_item.op;
            s1_px_reg    <= pixel_item.pixel_in;
            s1_col_reg   <= col_reg;
            s1_r1_reg    <= (row_reg >= IMG_H_W'(1));
            s1_r2_reg    <= (row_reg >= IMG_H_W'(2));
            s1_last_reg  <= last_a;
            s1_c0_reg    <= (col_reg == '0);
            above_rd_reg <= above_mem[col_reg];
            mid_rd_reg   <= mid_mem[col_reg];
        end
    end

    always_comb
    begin
        px_v   = (s1_op_reg == OP_PIXEL) ? s1_px_reg : mid_rd_reg;
        px_mid = s1_r1_reg ? mid_rd_reg : px_v;
        px_top = s1_r2_reg ? above_rd_reg : px_mid;
        new_col[0] = px_top;
        new_col[1] = px_mid;
        new_col[2] = px_v;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            if (s1_r1_reg)
            begin
                above_mem[s1_col_reg] <= mid_rd_reg;
            end
            mid_mem[s1_col_reg] <= px_v;
        end
    end

    // left column is replicated at the start of a row
    always_comb
    begin
        win_next = win_reg;
        if (s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                if (s1_c0_reg)
                begin
                    win_next[r][1] = new_col[r];
                    win_next[r][2] = new_col[r];
                end
                else
                begin
                    win_next[r][0] = win_reg[r][1];
                    win_next[r][1] = win_reg[r][2];
                    win_next[r][2] = new_col[r];
                end
            end
        end
    end

    assign e_mid  = s1_r1_reg && !s1_c0_reg;
    assign e_edge = s1_r1_reg && s1_last_reg;

    assign q_push           = s1_valid_reg && (e_mid || e_edge);
    assign q_data.win       = win_next;
    assign q_data.emit_mid  = e_mid;
    assign q_data.emit_edge = e_edge;

endmodule

>>> design/ced_back.sv
// Back end: compass kernels, max, threshold; one result per cycle unless stalled.
module ced_back
    import ced_pkg::*;
#(
    parameter int RESULT_DEPTH = RESULT_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [THR_W-1:0]                  threshold,
    input  logic                              q_empty,
    input  win_rec_t                          q_data,
    output logic                              q_pop,
    input  logic [$clog2(RESULT_DEPTH+1)-1:0] r_count,
    output logic                              r_push,
    output out_item_t                         r_data
);

    localparam int RC_W = $clog2(RESULT_DEPTH + 1);

    back_phase_t phase_reg, phase_next;

    logic issue, sel_edge, res_last;
    logic signed [RESP_W-1:0] p [3][3];
    logic signed [RESP_W-1:0] east, north, ne, nw;

    logic                     b1_valid_reg;
    logic                     b1_last_reg;
    logic signed [RESP_W-1:0] resp_reg [4];

    logic                     b2_valid_reg;
    logic                     b2_last_reg;
    logic [MAG_W-1:0]         abs_reg [4];

    logic [MAG_W-1:0] max_a, max_b, mag;

    assign issue = !q_empty && (((RC_W + 1)'(r_count) + (RC_W + 1)'(b1_valid_reg)
                   + (RC_W + 1)'(b2_valid_reg)) < (RC_W + 1)'(RESULT_DEPTH));

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_FIRST:
            begin
                if (issue && q_data.emit_mid && q_data.emit_edge)
                    phase_next = PH_SECOND;
            end
            PH_SECOND:
            begin
                if (issue)
                    phase_next = PH_FIRST;
            end
            default:
            begin
                phase_next = PH_FIRST;
            end
        endcase
    end

    always_comb
    begin
        case (phase_reg)
            PH_FIRST:
            begin
                sel_edge = !q_data.emit_mid;
                res_last = !(q_data.emit_mid && q_data.emit_edge);
                q_pop    = issue && !(q_data.emit_mid && q_data.emit_edge);
            end
            PH_SECOND:
            begin
                sel_edge = 1'b1;
                res_last = 1'b1;
                q_pop    = issue;
            end
            default:
            begin
                sel_edge = 1'b0;
                res_last = 1'b0;
                q_pop    = 1'b0;
            end
        endcase
    end

    // right-edge result replicates the last column
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            p[r][0] = signed'(RESP_W'(sel_edge ? q_data.win[r][1] : q_data.win[r][0]));
            p[r][1] = signed'(RESP_W'(sel_edge ? q_data.win[r][2] : q_data.win[r][1]));
            p[r][2] = signed'(RESP_W'(q_data.win[r][2]));
        end
        east  = (p[0][2] + p[1][2] + p[1][2] + p[2][2])
              - (p[0][0] + p[1][0] + p[1][0] + p[2][0]);
        north = (p[0][0] + p[0][1] + p[0][1] + p[0][2])
              - (p[2][0] + p[2][1] + p[2][1] + p[2][2]);
        ne    = (p[0][2] + p[0][2] + p[0][1] + p[1][2])
              - (p[1][0] + p[2][1] + p[2][0] + p[2][0]);
        nw    = (p[0][0] + p[0][0] + p[0][1] + p[1][0])
              - (p[1][2] + p[2][1] + p[2][2] + p[2][2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_FIRST;
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            b1_valid_reg <= issue;
            b2_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b1_last_reg <= res_last;
            resp_reg[0] <= east;
            resp_reg[1] <= north;
            resp_reg[2] <= ne;
            resp_reg[3] <= nw;
        end
        if (b1_valid_reg)
        begin
            b2_last_reg <= b1_last_reg;
            for (int k = 0; k < 4; k++)
            begin
                abs_reg[k] <= resp_reg[k][RESP_W-1] ? MAG_W'(-resp_reg[k])
                                                    : MAG_W'(resp_reg[k]);
            end
        end
    end

    always_comb
    begin
        max_a = (abs_reg[1] > abs_reg[0]) ? abs_reg[1] : abs_reg[0];
        max_b = (abs_reg[3] > abs_reg[2]) ? abs_reg[3] : abs_reg[2];
        mag   = (max_b > max_a) ? max_b : max_a;
    end

    assign r_push             = b2_valid_reg;
    assign r_data.magnitude   = mag;
    assign r_data.edge_pixel  = (mag >= threshold) ? EDGE_OUT : NO_EDGE_OUT;
    assign r_data.last_in_run = b2_last_reg;

endmodule

>>> design/compass_edge_detector_3x3_top.sv
// Top level of the 3x3 compass edge detector: configuration registers and queues.
//
// Input side: drive pixel_item with push; a transfer happens when push is high
// and full is low. op selects a pixel or a flush item; one row of flush items
// after the last image row supplies the bottom border.
// Result side: while empty is low the oldest result is on result; pop takes it.
// Each row but the top one gives one result from its second pixel onwards, two
// for its last pixel; last_in_run marks the final result of an input transfer.
// Throughput: one input transfer per clock while full is low, one result per
// clock while results are popped. An end-of-row transfer holds the kernel unit
// for both of its results; the window queue absorbs it. A result passes through
// the line-buffer read, the window queue and the kernel pipe to the result port.
// Configuration: cfg_valid/cfg_ready with cfg_index 0 threshold, 1 width,
// 2 height; write only while the block is idle. cfg_ready is always high.
// Reset clears counters, window, queues and loads default settings; line
// buffer contents are not cleared. When pop is held low, results pile up in
// the result queue, the window queue then fills, and full rises.
module compass_edge_detector_3x3_top
    import ced_pkg::*;
#(
    parameter int MAX_WIDTH    = MAX_WIDTH_DEF,
    parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF,
    parameter int RESULT_DEPTH = RESULT_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    output logic                  full,
    input  in_item_t              pixel_item,
    output logic                  empty,
    input  logic                  pop,
    output out_item_t             result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int RC_W = $clog2(RESULT_DEPTH + 1);
    localparam int REC_W = $bits(win_rec_t);
    localparam int RES_W = $bits(out_item_t);

    logic [THR_W-1:0]   threshold_reg;
    logic [IMG_W_W-1:0] width_reg;
    logic [IMG_H_W-1:0] height_reg;
    frame_cfg_t         frame_cfg;

    logic             q_push, q_pop, q_empty;
    win_rec_t         q_wr, q_head;
    logic [REC_W-1:0] q_rd_bits;
    logic [QC_W-1:0]  q_count;

    logic             r_push;
    out_item_t        r_wr;
    logic [RES_W-1:0] r_rd_bits;
    logic [RC_W-1:0]  r_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            width_reg     <= WIDTH_RESET;
            height_reg    <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_THRESHOLD: threshold_reg <= cfg_data[THR_W-1:0];
                REG_WIDTH:     width_reg     <= cfg_data[IMG_W_W-1:0];
                REG_HEIGHT:    height_reg    <= cfg_data[IMG_H_W-1:0];
                default:       ;
            endcase
        end
    end

    assign frame_cfg.image_width  = width_reg;
    assign frame_cfg.image_height = height_reg;

    ced_front #(
        .MAX_WIDTH   (MAX_WIDTH),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel_item (pixel_item),
        .frame_cfg  (frame_cfg),
        .q_count    (q_count),
        .q_push     (q_push),
        .q_data     (q_wr)
    );

    ced_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_win_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wr),
        .rd_en   (q_pop),
        .rd_data (q_rd_bits),
        .count   (q_count),
        .empty   (q_empty)
    );

    assign q_head = win_rec_t'(q_rd_bits);

    ced_back #(
        .RESULT_DEPTH (RESULT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .threshold (threshold_reg),
        .q_empty   (q_empty),
        .q_data    (q_head),
        .q_pop     (q_pop),
        .r_count   (r_count),
        .r_push    (r_push),
        .r_data    (r_wr)
    );

    ced_queue #(
        .WIDTH (RES_W),
        .DEPTH (RESULT_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (r_push),
        .wr_data (r_wr),
        .rd_en   (pop && !empty),
        .rd_data (r_rd_bits),
        .count   (r_count),
        .empty   (empty)
    );

    assign result = out_item_t'(r_rd_bits);

endmodule

>>> dv/ced_edge_checker.sv
// Checker for the compass edge detector: mirrors the pixel stream and compares every result.
module ced_edge_checker
    import ced_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic                  full,
    input  in_item_t              pixel_item,
    input  logic                  empty,
    input  logic                  pop,
    input  out_item_t             result,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    checked
);

    logic [THR_W-1:0]   thr;
    logic [IMG_W_W-1:0] img_w;
    logic [IMG_H_W-1:0] img_h;
    logic [PIX_W-1:0]   above_line [MAX_WIDTH];
    logic [PIX_W-1:0]   middle_line [MAX_WIDTH];
    logic [PIX_W-1:0]   win [3][3];
    int unsigned        col;
    int unsigned        row;
    out_item_t          expected_edges [$];
    out_item_t          want;
    int                 fails = 0;
    int                 n_checked = 0;

    function automatic int abs_i(int v);
        return (v < 0) ? -v : v;
    endfunction

    // largest compass response over window columns ca, cb, cc
    function automatic logic [MAG_W-1:0] compass_mag(int ca, int cb, int cc);
        int w [3][3];
        int east;
        int north;
        int ne;
        int nw;
        int m;
        for (int r = 0; r < 3; r++)
        begin
            w[r][0] = win[r][ca];
            w[r][1] = win[r][cb];
            w[r][2] = win[r][cc];
        end
        east  = (w[0][2] + 2 * w[1][2] + w[2][2]) - (w[0][0] + 2 * w[1][0] + w[2][0]);
        north = (w[0][0] + 2 * w[0][1] + w[0][2]) - (w[2][0] + 2 * w[2][1] + w[2][2]);
        ne    = 2 * w[0][2] + w[0][1] + w[1][2] - w[1][0] - w[2][1] - 2 * w[2][0];
        nw    = 2 * w[0][0] + w[0][1] + w[1][0] - w[1][2] - w[2][1] - 2 * w[2][2];
        m = abs_i(east);
        if (abs_i(north) > m) m = abs_i(north);
        if (abs_i(ne) > m) m = abs_i(ne);
        if (abs_i(nw) > m) m = abs_i(nw);
        return MAG_W'(m);
    endfunction

    function automatic void queue_edge(logic [MAG_W-1:0] mag, logic last);
        out_item_t e;
        e.edge_pixel  = (mag >= thr) ? EDGE_OUT : NO_EDGE_OUT;
        e.magnitude   = mag;
        e.last_in_run = last;
        expected_edges.insert(expected_edges.size(), e);
    endfunction

    function automatic void predict_edges(in_item_t it);
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned c;
        int unsigned r;
        logic [PIX_W-1:0] v;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        logic last;
        w_eff = img_w;
        h_eff = img_h;
        if (w_eff < MIN_DIM) w_eff = MIN_DIM;
        if (w_eff > MAX_WIDTH) w_eff = MAX_WIDTH;
        if (h_eff < MIN_DIM) h_eff = MIN_DIM;
        if (h_eff > MAX_HEIGHT) h_eff = MAX_HEIGHT;
        c = (col >= MAX_WIDTH) ? MAX_WIDTH - 1 : col;
        r = row;
        // flush on the top row is dropped
        if (it.op == OP_FLUSH && r == 0) return;
        v   = (it.op == OP_FLUSH) ? middle_line[c] : it.pixel_in;
        mid = (r >= 1) ? middle_line[c] : v;
        top = (r >= 2) ? above_line[c] : mid;
        if (r >= 1) above_line[c] = middle_line[c];
        middle_line[c] = v;
        if (c == 0)
        begin
            win[0][1] = top;
            win[0][2] = top;
            win[1][1] = mid;
            win[1][2] = mid;
            win[2][1] = v;
            win[2][2] = v;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                win[k][0] = win[k][1];
                win[k][1] = win[k][2];
            end
            win[0][2] = top;
            win[1][2] = mid;
            win[2][2] = v;
        end
        last = (c >= w_eff - 1);
        if (r >= 1 && c >= 1) queue_edge(compass_mag(0, 1, 2), !last);
        if (r >= 1 && last) queue_edge(compass_mag(1, 2, 2), 1'b1);
        if (last)
        begin
            col = 0;
            row = (r >= h_eff) ? 0 : r + 1;
        end
        else
        begin
            col = c + 1;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr   = THRESHOLD_RESET;
            img_w = WIDTH_RESET;
            img_h = HEIGHT_RESET;
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                above_line[i]  = '0;
                middle_line[i] = '0;
            end
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    win[i][j] = '0;
            col = 0;
            row = 0;
            expected_edges.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_THRESHOLD: thr   = cfg_data[THR_W-1:0];
                    REG_WIDTH:     img_w = cfg_data[IMG_W_W-1:0];
                    REG_HEIGHT:    img_h = cfg_data[IMG_H_W-1:0];
                    default:       ;
                endcase
            end
            if (push && !full) predict_edges(pixel_item);
            if (pop && !empty)
            begin
                if (expected_edges.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result, expected none, got %p", $time, result);
                end
                else
                begin
                    want = expected_edges.pop_front();
                    n_checked++;
                    if (result.edge_pixel !== want.edge_pixel)
                    begin
                        fails++;
                        $display("%0t: edge_pixel expected %0d, got %0d",
                                 $time, want.edge_pixel, result.edge_pixel);
                    end
                    if (result.magnitude !== want.magnitude)
                    begin
                        fails++;
                        $display("%0t: magnitude expected %0d, got %0d",
                                 $time, want.magnitude, result.magnitude);
                    end
                    if (result.last_in_run !== want.last_in_run)
                    begin
                        fails++;
                        $display("%0t: last_in_run expected %0d, got %0d",
                                 $time, want.last_in_run, result.last_in_run);
                    end
                end
            end
        end
        fail_count <= fails;
        pending    <= expected_edges.size();
        checked    <= n_checked;
    end

endmodule

>>> dv/tb_compass_edge_detector_3x3_top.sv
// Testbench top for the compass edge detector: stimulus, idling and the verdict.
module tb_compass_edge_detector_3x3_top;
    import ced_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 600;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(3);

    logic                  clk        = 1'b0;
    logic                  rst_n      = 1'b0;
    logic                  push       = 1'b0;
    logic                  full;
    in_item_t              pixel_item = '0;
    logic                  empty;
    logic                  pop        = 1'b0;
    out_item_t             result;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = REG_THRESHOLD;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;

    int fail_count;
    int pending;
    int results_checked;
    int cycle_count = 0;
    int items_sent  = 0;
    int frames_sent = 0;
    int reg_writes  = 0;
    bit src_burst   = 1'b0;
    bit sink_burst  = 1'b0;

    compass_edge_detector_3x3_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel_item (pixel_item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    ced_edge_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel_item (pixel_item),
        .empty      (empty),
        .pop        (pop),
        .result     (result),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .checked    (results_checked)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("compass_edge_detector_3x3_top test failed");
            $finish;
        end
    end

    // result side: random stall before each transfer
    initial
    begin : result_drain
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = sink_burst ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    task automatic send_item(logic op, logic [PIX_W-1:0] px);
        int gap;
        gap = src_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        pixel_item <= '{op: op, pixel_in: px};
        do @(posedge clk); while (full);
    endtask

    // hold the sender until every expected result has been taken
    task automatic settle();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        do @(posedge clk); while (!cfg_ready);
        reg_writes++;
    endtask

    task automatic configure(int thr, int w, int h);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        cfg_valid <= 1'b0;
    endtask

    function automatic int clamp(int v, int lo, int hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic logic [PIX_W-1:0] draw_pixel(int mode, int base);
        case (mode)
            0:       return PIX_W'($urandom_range(0, 255));
            1:       return PIX_W'(base + $urandom_range(0, 7));
            2:       return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return PIX_W'(base);
        endcase
    endfunction

    // noise: chance in 16 that an item's op is flipped
    task automatic send_rows(int w, int first_row, int last_row, int h, int mode, int noise);
        int base;
        int r;
        int c;
        logic op;
        logic [PIX_W-1:0] px;
        base = $urandom_range(0, 248);
        for (r = first_row; r <= last_row; r++)
        begin
            for (c = 0; c < w; c++)
            begin
                px = draw_pixel(mode, base);
                op = (r >= h) ? OP_FLUSH : OP_PIXEL;
                if ($urandom_range(0, 15) < noise) op = !op;
                if (r == 0 && op == OP_FLUSH)
                begin
                    send_item(OP_FLUSH, px);
                    op = OP_PIXEL;
                end
                send_item(op, px);
                items_sent++;
            end
        end
    endtask

    initial
    begin : stimulus
        logic [PIX_W-1:0] dir_px [12];
        logic             dir_op [12];
        int wr;
        int hr;
        int thr;
        int w_eff;
        int h_eff;
        int n;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // flush on row zero is ignored
        send_item(OP_FLUSH, 8'hA5);
        settle();

        // 3x3 frame, undersized width and height, threshold zero; includes a
        // flush in a middle row and a pixel in the bottom row
        configure(0, 0, 2);
        dir_px = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
                   8'h5A, 8'h00, 8'hFF, 8'h3C, 8'hC3, 8'hFF};
        dir_op = '{OP_PIXEL, OP_PIXEL, OP_PIXEL, OP_PIXEL, OP_PIXEL, OP_PIXEL,
                   OP_FLUSH, OP_PIXEL, OP_PIXEL, OP_FLUSH, OP_FLUSH, OP_PIXEL};
        for (int i = 0; i < 12; i++)
            send_item(dir_op[i], dir_px[i]);
        frames_sent++;
        settle();

        // vertical step gives the full 1020 magnitude, at the threshold
        configure(1020, 1, 1);
        for (int i = 0; i < 12; i++)
            send_item((i >= 9) ? OP_FLUSH : OP_PIXEL, (i % 3 == 0) ? 8'hFF : 8'h00);
        frames_sent++;
        settle();

        // oversized width acts as the full line length; the second row is cut
        // short once it has given results
        items_sent = 0;
        configure($urandom_range(0, 1023), 1023, 3);
        send_rows(MAX_WIDTH_DEF, 0, 0, 3, 0, 0);
        send_rows(2, 1, 1, 3, 0, 0);
        settle();
        write_reg(REG_WIDTH, 3);
        cfg_valid <= 1'b0;
        send_item(OP_PIXEL, PIX_W'($urandom_range(0, 255)));
        items_sent++;
        send_rows(3, 2, 3, 3, 0, 0);
        frames_sent++;

        while (items_sent < RANDOM_ITEMS)
        begin
            wr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            hr = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
            case ($urandom_range(0, 4))
                0:       thr = 0;
                1:       thr = 1023;
                2:       thr = THRESHOLD_RESET;
                3:       thr = $urandom_range(0, 1023);
                default: thr = $urandom_range(0, 200);
            endcase
            w_eff = clamp(wr, MIN_DIM, MAX_WIDTH_DEF);
            h_eff = clamp(hr, MIN_DIM, MAX_HEIGHT);
            src_burst  = ($urandom_range(0, 3) == 0);
            sink_burst = ($urandom_range(0, 3) == 0);
            settle();
            configure(thr, wr, hr);
            n = $urandom_range(1, 2);
            repeat (n)
            begin
                send_rows(w_eff, 0, h_eff, h_eff, $urandom_range(0, 3),
                          ($urandom_range(0, 3) == 0) ? 2 : 0);
                frames_sent++;
            end
        end
        src_burst  = 1'b0;
        sink_burst = 1'b0;

        // width shrunk part way through a row
        settle();
        configure($urandom_range(0, 300), 8, 4);
        send_rows(8, 0, 1, 4, 0, 0);
        for (int i = 0; i < 5; i++)
            send_item(OP_PIXEL, PIX_W'($urandom_range(0, 255)));
        settle();
        write_reg(REG_THRESHOLD, $urandom_range(0, 300));
        write_reg(REG_WIDTH, 4);
        cfg_valid <= 1'b0;
        send_item(OP_PIXEL, PIX_W'($urandom_range(0, 255)));
        send_rows(4, 3, 4, 4, 0, 0);
        frames_sent++;

        // oversized height, cut short part way through the frame
        settle();
        configure(THRESHOLD_RESET, 4, 8191);
        send_rows(4, 0, 5, 8191, 1, 0);
        settle();
        write_reg(REG_HEIGHT, 3);
        write_reg(REG_UNUSED, $urandom_range(0, 8191));
        cfg_valid <= 1'b0;
        send_rows(4, 6, 6, 3, 0, 0);
        frames_sent++;

        settle();
        $display("Ran %0d frames (widths 3..512, heights 3..4096) and %0d register writes;",
                 frames_sent, reg_writes);
        $display("%0d results compared, with flush, ignored and mid-frame register cases.",
                 results_checked);
        if (fail_count == 0)
            $display("compass_edge_detector_3x3_top test passed");
        else
            $display("compass_edge_detector_3x3_top test failed");
        $finish;
    end

endmodule
